>>> hw/rtl/best_fit_allocator_coalescing_unit_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef BEST_FIT_ALLOCATOR_COALESCING_UNIT_ASSERT_SVH
`define BEST_FIT_ALLOCATOR_COALESCING_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define BFA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Signal holds its value in the cycle after the condition.
`define BFA_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

>>> hw/rtl/bfa_pkg.sv
// Package with the allocator's sizes, codes and types.
package bfa_pkg;
  localparam int unsigned NodeBytes = 4096;
  localparam int unsigned MaxNodes = 16;
  localparam int unsigned FreeEntries = 64;
  localparam int unsigned UsedEntries = 64;
  localparam int unsigned FreeIdxW = $clog2(FreeEntries);
  localparam int unsigned UsedIdxW = $clog2(UsedEntries);
  localparam int unsigned NodeW = $clog2(MaxNodes + 1);
  localparam int unsigned NodeOffW = $clog2(NodeBytes);
  localparam int unsigned AddrW = NodeOffW + $clog2(MaxNodes) + 1;
  localparam int unsigned LenW = 13;
  localparam int unsigned OutAddrW = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned FreeDataW = 2 * AddrW;
  localparam int unsigned UsedDataW = AddrW + LenW;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncRelease = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StOk = 3'd0,
    StBadLength = 3'd1,
    StExhausted = 3'd2,
    StNotAllocated = 3'd3,
    StTableFull = 3'd4
  } status_e;
endpackage

>>> hw/rtl/bfa_ram.sv
// Generic single-port RAM with a registered read.
module bfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> hw/rtl/best_fit_allocator_coalescing_unit.sv
// Top level of the best-fit allocator with coalescing.
//  channel | valid / stall       | payload
//  request | req_valid_i / _o    | func_i, length_i, address_i
//  result  | res_valid_o / _i    | granted_address_o, status_o
// A request scans the used and then the free table, each one entry a cycle through
// its single RAM port.
// An allocate with a bad length skips the scans and goes straight to SDone.
// An allocate scans used then free entries; a release scans used then free.
// Reset clears the valid bits but that of free entry 0, and sets up the first node in flip-flops at once.
// A result waits in its output register while res_stall_i is high; the next
// request is taken only after that.
module best_fit_allocator_coalescing_unit
  import bfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  logic                func_i,
  input  logic [LenW-1:0]     length_i,
  input  logic [15:0]         address_i,
  output logic                res_valid_o,
  input  logic                res_stall_i,
  output logic [OutAddrW-1:0] granted_address_o,
  output logic [StatusW-1:0]  status_o
);
`include "best_fit_allocator_coalescing_unit_assert.svh"

  typedef enum logic [2:0] {
    SIdle, SUsedScan, SFreeScan, SDecide, SDone
  } state_e;

  state_e state_q;
  logic func_q;
  logic [LenW-1:0] len_q;
  logic [AddrW-1:0] addr_q;
  logic [FreeEntries-1:0] fvalid_q;
  logic [UsedEntries-1:0] uvalid_q;
  logic [NodeW-1:0] nodes_q;
  logic [FreeIdxW:0] fcnt_q;
  logic [UsedIdxW:0] ucnt_q;
  logic rd_pend_q;
  logic [FreeIdxW-1:0] frd_idx_q;
  logic [UsedIdxW-1:0] urd_idx_q;

  logic u_hit_q, f_free_hit_q, best_hit_q, p_hit_q, n_hit_q;
  logic [UsedIdxW-1:0] u_idx_q;
  logic [LenW-1:0] u_len_q;
  logic [FreeIdxW-1:0] best_idx_q, p_idx_q, n_idx_q, fslot_q;
  logic [AddrW-1:0] best_left_q, best_right_q, best_size_q, n_right_q;
  logic [OutAddrW-1:0] gaddr_q;
  logic [StatusW-1:0] status_q;
  logic out_valid_q;

  logic f_we, u_we;
  logic [FreeIdxW-1:0] f_addr;
  logic [UsedIdxW-1:0] u_addr;
  logic [FreeDataW-1:0] f_wdata, f_rdata;
  logic [UsedDataW-1:0] u_wdata, u_rdata;
  logic [AddrW-1:0] f_left, f_right, f_size, u_start, rel_right;
  logic [LenW-1:0] u_rlen;

  logic f_entry0_q;

  bfa_ram #(.Width(FreeDataW), .Depth(FreeEntries)) u_free_ram (
    .clk_i, .we_i(f_we), .addr_i(f_addr), .wdata_i(f_wdata), .rdata_o(f_rdata)
  );
  bfa_ram #(.Width(UsedDataW), .Depth(UsedEntries)) u_used_ram (
    .clk_i, .we_i(u_we), .addr_i(u_addr), .wdata_i(u_wdata), .rdata_o(u_rdata)
  );

  // Entry 0 of the free table is served from its reset value until written.
  assign f_left = f_entry0_q && (frd_idx_q == '0) ? '0 : f_rdata[FreeDataW-1:AddrW];
  assign f_right = f_entry0_q && (frd_idx_q == '0) ? AddrW'(NodeBytes) : f_rdata[AddrW-1:0];
  assign f_size = f_right - f_left;
  assign u_start = u_rdata[UsedDataW-1:LenW];
  assign u_rlen = u_rdata[LenW-1:0];
  assign rel_right = addr_q + AddrW'(u_len_q);

  logic fire_in;
  assign req_stall_o = (state_q != SIdle) || out_valid_q;
  assign fire_in = req_valid_i && !req_stall_o;
  assign res_valid_o = out_valid_q;
  assign granted_address_o = gaddr_q;
  assign status_o = status_q;

  logic [AddrW-1:0] node_base;
  assign node_base = AddrW'(nodes_q) << NodeOffW;

  // Allocation decision, registered in SDecide.
  logic alloc_new;
  logic [FreeIdxW-1:0] alloc_idx;
  logic [AddrW-1:0] alloc_left, alloc_right;
  always_comb begin
    alloc_new = !best_hit_q;
    alloc_idx = best_hit_q ? best_idx_q : fslot_q;
    alloc_left = best_hit_q ? best_left_q : node_base;
    alloc_right = best_hit_q ? best_right_q : node_base + AddrW'(NodeBytes);
  end

  always_comb begin
    f_we = 1'b0;
    u_we = 1'b0;
    f_addr = fcnt_q[FreeIdxW-1:0];
    u_addr = ucnt_q[UsedIdxW-1:0];
    f_wdata = {addr_q, rel_right};
    u_wdata = {addr_q, len_q};
    if (state_q == SDecide && status_q == StOk) begin
      if (func_q == FuncAlloc) begin
        u_we = 1'b1;
        u_addr = u_idx_q;
        u_wdata = {alloc_left, len_q};
        f_we = (alloc_right - alloc_left) > AddrW'(len_q);
        f_addr = alloc_idx;
        f_wdata = {alloc_left + AddrW'(len_q), alloc_right};
      end else begin
        f_we = 1'b1;
        if (p_hit_q) begin
          f_addr = p_idx_q;
          f_wdata = {best_left_q, n_hit_q ? n_right_q : rel_right};
        end else if (n_hit_q) begin
          f_addr = n_idx_q;
          f_wdata = {addr_q, best_right_q};
        end else begin
          f_addr = fslot_q;
          f_wdata = {addr_q, rel_right};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      fvalid_q <= FreeEntries'(1);
      uvalid_q <= '0;
      nodes_q <= NodeW'(1);
      out_valid_q <= 1'b0;
      f_entry0_q <= 1'b1;
      rd_pend_q <= 1'b0;
      fcnt_q <= '0;
      ucnt_q <= '0;
      gaddr_q <= '0;
      status_q <= StOk;
    end else begin
      if (out_valid_q && !res_stall_i) out_valid_q <= 1'b0;
      if (f_we && f_addr == '0) f_entry0_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (fire_in) begin
            func_q <= func_i;
            len_q <= length_i;
            addr_q <= AddrW'(address_i);
            ucnt_q <= '0;
            fcnt_q <= '0;
            rd_pend_q <= 1'b0;
            u_hit_q <= 1'b0;
            f_free_hit_q <= 1'b0;
            best_hit_q <= 1'b0;
            p_hit_q <= 1'b0;
            n_hit_q <= 1'b0;
            if (func_i == FuncAlloc &&
                (length_i == '0 || length_i > LenW'(NodeBytes))) begin
              status_q <= StBadLength;
              state_q <= SDone;
            end else begin
              status_q <= StOk;
              state_q <= SUsedScan;
            end
          end
        end
        SUsedScan: begin
          urd_idx_q <= ucnt_q[UsedIdxW-1:0];
          rd_pend_q <= (ucnt_q <= (UsedIdxW+1)'(UsedEntries - 1));
          if (ucnt_q <= (UsedIdxW+1)'(UsedEntries - 1)) ucnt_q <= ucnt_q + (UsedIdxW+1)'(1);
          if (rd_pend_q && !u_hit_q) begin
            if (func_q == FuncAlloc) begin
              if (!uvalid_q[urd_idx_q]) begin
                u_hit_q <= 1'b1;
                u_idx_q <= urd_idx_q;
              end
            end else if (uvalid_q[urd_idx_q] && u_start == addr_q) begin
              u_hit_q <= 1'b1;
              u_idx_q <= urd_idx_q;
              u_len_q <= u_rlen;
            end
          end
          if (ucnt_q == (UsedIdxW+1)'(UsedEntries) && !rd_pend_q) begin
            state_q <= SFreeScan;
          end
        end
        SFreeScan: begin
          frd_idx_q <= fcnt_q[FreeIdxW-1:0];
          rd_pend_q <= (fcnt_q <= (FreeIdxW+1)'(FreeEntries - 1));
          if (fcnt_q <= (FreeIdxW+1)'(FreeEntries - 1)) fcnt_q <= fcnt_q + (FreeIdxW+1)'(1);
          if (rd_pend_q) begin
            if (!fvalid_q[frd_idx_q]) begin
              if (!f_free_hit_q) begin
                f_free_hit_q <= 1'b1;
                fslot_q <= frd_idx_q;
              end
            end else if (func_q == FuncAlloc) begin
              if (f_size >= AddrW'(len_q) && (!best_hit_q || f_size < best_size_q ||
                  (f_size == best_size_q && f_left < best_left_q))) begin
                best_hit_q <= 1'b1;
                best_idx_q <= frd_idx_q;
                best_size_q <= f_size;
                best_left_q <= f_left;
                best_right_q <= f_right;
              end
            end else begin
              if (!p_hit_q && f_right == addr_q && addr_q[NodeOffW-1:0] != '0) begin
                p_hit_q <= 1'b1;
                p_idx_q <= frd_idx_q;
                best_left_q <= f_left;
              end
              if (!n_hit_q && f_left == rel_right && rel_right[NodeOffW-1:0] != '0) begin
                n_hit_q <= 1'b1;
                n_idx_q <= frd_idx_q;
                n_right_q <= f_right;
                best_right_q <= f_right;
              end
            end
          end
          if (fcnt_q == (FreeIdxW+1)'(FreeEntries) && !rd_pend_q) begin
            state_q <= SDecide;
            if (func_q == FuncAlloc) begin
              if (!u_hit_q) status_q <= StTableFull;
              else if (!best_hit_q && nodes_q >= NodeW'(MaxNodes)) status_q <= StExhausted;
              else if (!best_hit_q && !f_free_hit_q) status_q <= StTableFull;
            end else begin
              if (!u_hit_q) status_q <= StNotAllocated;
              else if (!p_hit_q && !n_hit_q && !f_free_hit_q) status_q <= StTableFull;
            end
          end
        end
        SDecide: begin
          state_q <= SDone;
          gaddr_q <= '0;
          if (status_q == StOk) begin
            if (func_q == FuncAlloc) begin
              gaddr_q <= alloc_left[OutAddrW-1:0];
              uvalid_q[u_idx_q] <= 1'b1;
              if (alloc_new) nodes_q <= nodes_q + NodeW'(1);
              fvalid_q[alloc_idx] <= (alloc_right - alloc_left) > AddrW'(len_q);
            end else begin
              uvalid_q[u_idx_q] <= 1'b0;
              if (p_hit_q && n_hit_q) fvalid_q[n_idx_q] <= 1'b0;
              else if (!p_hit_q && !n_hit_q) fvalid_q[fslot_q] <= 1'b1;
            end
          end
        end
        SDone: begin
          if (status_q != StOk) gaddr_q <= '0;
          out_valid_q <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `BFA_ASSERT(a_no_accept_busy, clk_i, rst_ni, fire_in |-> state_q == SIdle && !out_valid_q,
              "request accepted while busy")
  `BFA_ASSERT_HOLD(a_res_hold, clk_i, rst_ni, out_valid_q && res_stall_i, status_o,
                   "stalled result changed")
  `BFA_ASSERT(a_grant_zero, clk_i, rst_ni, (out_valid_q && status_q != StOk) |-> gaddr_q == '0,
              "error result carries an address")
endmodule

>>> test/tb_best_fit_allocator_coalescing_unit.sv
// Testbench for the best-fit allocator: directed table, then phased random traffic.
`timescale 1ns / 1ps

module tb_best_fit_allocator_coalescing_unit;
  import bfa_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                req_valid_i;
  logic                req_stall_o;
  logic                func_i;
  logic [LenW-1:0]     length_i;
  logic [15:0]         address_i;
  logic                res_valid_o;
  logic                res_stall_i;
  logic [OutAddrW-1:0] granted_address_o;
  logic [StatusW-1:0]  status_o;

  best_fit_allocator_coalescing_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid_i), .req_stall_o(req_stall_o),
    .func_i(func_i), .length_i(length_i), .address_i(address_i),
    .res_valid_o(res_valid_o), .res_stall_i(res_stall_i),
    .granted_address_o(granted_address_o), .status_o(status_o)
  );

  typedef struct {
    logic [15:0] grant;
    status_e     st;
  } grant_t;

  typedef struct {
    logic        op;
    int unsigned len;
    int unsigned adr;
    bit          typed;
    logic [15:0] grant;
    status_e     st;
  } dir_row_t;

  grant_t      pending_grants[$];
  dir_row_t    dir_rows[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned results_seen = 0;
  int unsigned ok_allocs = 0, ok_releases = 0, rejects = 0;
  bit          quiet = 0;
  int unsigned hold_asked = 0, hold_taken = 0, hold_left = 0;

  bit          fv[FreeEntries];
  int unsigned fl[FreeEntries], fr[FreeEntries];
  bit          uv[UsedEntries];
  int unsigned us[UsedEntries], ul[UsedEntries];
  int unsigned nodes;

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_best_fit_allocator_coalescing_unit: done, errors");
      $finish;
    end
  end

  function automatic void pool_reset();
    for (int i = 0; i < FreeEntries; i++) fv[i] = 0;
    for (int i = 0; i < UsedEntries; i++) uv[i] = 0;
    fv[0] = 1; fl[0] = 0; fr[0] = NodeBytes;
    nodes = 1;
  endfunction

  function automatic status_e pool_alloc(int unsigned len, output logic [15:0] g);
    int u, b;
    int unsigned sz, bs, bl, left;
    g = 0; u = -1; b = -1; bs = 0; bl = 0;
    if (len == 0 || len > NodeBytes) return StBadLength;
    for (int i = 0; i < UsedEntries; i++) if (!uv[i]) begin u = i; break; end
    if (u < 0) return StTableFull;
    for (int i = 0; i < FreeEntries; i++) begin
      if (!fv[i]) continue;
      sz = fr[i] - fl[i];
      if (sz < len) continue;
      if (b < 0 || sz < bs || (sz == bs && fl[i] < bl)) begin
        b = i; bs = sz; bl = fl[i];
      end
    end
    if (b < 0) begin
      if (nodes >= MaxNodes) return StExhausted;
      for (int i = 0; i < FreeEntries; i++) if (!fv[i]) begin b = i; break; end
      if (b < 0) return StTableFull;
      fv[b] = 1; fl[b] = nodes * NodeBytes; fr[b] = fl[b] + NodeBytes;
      nodes++;
    end
    left = fl[b];
    if (fr[b] - left > len) fl[b] = left + len;
    else fv[b] = 0;
    uv[u] = 1; us[u] = left; ul[u] = len;
    g = left[15:0];
    return StOk;
  endfunction

  function automatic status_e pool_release(int unsigned adr);
    int u, p, n, f;
    int unsigned left, right;
    u = -1; p = -1; n = -1; f = -1;
    for (int i = 0; i < UsedEntries; i++)
      if (uv[i] && us[i] == adr) begin u = i; break; end
    if (u < 0) return StNotAllocated;
    left = adr; right = adr + ul[u];
    for (int i = 0; i < FreeEntries; i++) begin
      if (!fv[i]) continue;
      if (p < 0 && fr[i] == left && (left % NodeBytes) != 0) p = i;
      if (n < 0 && fl[i] == right && (right % NodeBytes) != 0) n = i;
    end
    if (p < 0 && n < 0) begin
      for (int i = 0; i < FreeEntries; i++) if (!fv[i]) begin f = i; break; end
      if (f < 0) return StTableFull;
    end
    uv[u] = 0;
    if (p >= 0 && n >= 0) begin
      fr[p] = fr[n]; fv[n] = 0;
    end else if (p >= 0) begin
      fr[p] = right;
    end else if (n >= 0) begin
      fl[n] = left;
    end else begin
      fv[f] = 1; fl[f] = left; fr[f] = right;
    end
    return StOk;
  endfunction

  function automatic int unsigned live_address();
    int idx[$];
    for (int i = 0; i < UsedEntries; i++) if (uv[i]) idx.insert(idx.size(), i);
    if (idx.size() == 0) return $urandom_range(0, 65535);
    return us[idx[$urandom_range(0, idx.size() - 1)]];
  endfunction

  task automatic send_request(logic op, int unsigned len, int unsigned adr,
                              bit typed, logic [15:0] tg, status_e ts);
    grant_t e;
    req_valid_i <= 1'b1;
    func_i      <= op;
    length_i    <= len[LenW-1:0];
    address_i   <= adr[15:0];
    do @(posedge clk_i); while (!(req_valid_i && !req_stall_o));
    if (op == FuncAlloc) e.st = pool_alloc(len, e.grant);
    else begin
      e.grant = 0;
      e.st = pool_release(adr);
    end
    if (e.st != StOk) rejects++;
    else if (op == FuncAlloc) ok_allocs++;
    else ok_releases++;
    if (typed) begin
      e.grant = tg;
      e.st = ts;
    end
    pending_grants.insert(pending_grants.size(), e);
    if (!quiet && $urandom_range(0, 99) < 6) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    grant_t e;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      results_seen++;
      if (pending_grants.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending_grants.pop_front();
        if (granted_address_o !== e.grant) begin
          $error("granted_address expected %0d actual %0d", e.grant, granted_address_o);
          errors++;
        end
        if (status_o !== e.st) begin
          $error("status expected %0d actual %0d", e.st, status_o);
          errors++;
        end
      end
    end
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= !quiet && ($urandom_range(0, 99) < 6);
    end
  end

  function automatic void add_row(logic op, int unsigned len, int unsigned adr,
                                  bit typed, logic [15:0] g, status_e st);
    dir_row_t r;
    r.op = op; r.len = len; r.adr = adr; r.typed = typed; r.grant = g; r.st = st;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  initial begin
    int unsigned wait_cycles;
    int unsigned pct_alloc, len, adr, roll;
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    func_i = FuncAlloc;
    length_i = '0;
    address_i = '0;
    res_stall_i = 1'b0;
    pool_reset();

    add_row(FuncAlloc, 0, 0, 1, 0, StBadLength);
    add_row(FuncAlloc, 4097, 0, 1, 0, StBadLength);
    add_row(FuncAlloc, 8191, 65535, 1, 0, StBadLength);
    add_row(FuncRelease, 8191, 65535, 1, 0, StNotAllocated);
    add_row(FuncAlloc, 4096, 0, 1, 0, StOk);
    add_row(FuncRelease, 0, 0, 1, 0, StOk);
    add_row(FuncAlloc, 1, 0, 1, 0, StOk);
    add_row(FuncAlloc, 100, 0, 1, 1, StOk);
    add_row(FuncAlloc, 4096, 0, 1, 4096, StOk);
    add_row(FuncRelease, 0, 1, 0, 0, StOk);
    add_row(FuncRelease, 0, 1, 1, 0, StNotAllocated);
    add_row(FuncRelease, 0, 0, 0, 0, StOk);
    add_row(FuncAlloc, 50, 0, 0, 0, StOk);
    add_row(FuncAlloc, 30, 0, 0, 0, StOk);
    add_row(FuncRelease, 0, 50, 0, 0, StOk);
    add_row(FuncRelease, 0, 4096, 0, 0, StOk);
    add_row(FuncAlloc, 8, 0, 0, 0, StOk);
    add_row(FuncRelease, 0, 0, 0, 0, StOk);
    add_row(FuncRelease, 0, 8, 0, 0, StOk);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].len, dir_rows[i].adr,
                   dir_rows[i].typed, dir_rows[i].grant, dir_rows[i].st);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: pct_alloc = 75;
        1: pct_alloc = 25;
        2: pct_alloc = 85;
        3: pct_alloc = 5;
        4: pct_alloc = 90;
        default: pct_alloc = 50;
      endcase
      quiet = (ph == 1);
      if (ph == 2) hold_asked++;
      if (ph == 4) begin
        req_valid_i <= 1'b0;
        while (pending_grants.size() != 0) @(posedge clk_i);
      end
      for (int k = 0; k < 100; k++) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < pct_alloc) begin
          if (roll < 3) len = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(4097, 8191);
          else if (ph == 2) len = (roll < 70) ? NodeBytes : $urandom_range(1, 4096);
          else if (ph == 4) len = $urandom_range(1, 16);
          else if (roll < 12) len = $urandom_range(1, 4096);
          else len = $urandom_range(1, 300);
          send_request(FuncAlloc, len, $urandom_range(0, 65535), 0, 0, StOk);
        end else begin
          adr = (roll < 6) ? $urandom_range(0, 65535) : live_address();
          send_request(FuncRelease, $urandom_range(0, 8191), adr, 0, 0, StOk);
        end
      end
    end
    quiet = 0;
    req_valid_i <= 1'b0;

    while (pending_grants.size() != 0) @(posedge clk_i);
    wait_cycles = 0;
    while (wait_cycles < 300) begin
      @(posedge clk_i);
      wait_cycles++;
    end

    $display("Covered %0d results: %0d grants, %0d releases, %0d rejected requests,",
             results_seen, ok_allocs, ok_releases, rejects);
    $display("with a long result stall, a drain pause and %0d nodes in use at the end.", nodes);
    if (errors == 0 && pending_grants.size() == 0)
      $display("tb_best_fit_allocator_coalescing_unit: done, clean");
    else
      $display("tb_best_fit_allocator_coalescing_unit: done, errors");
    $finish;
  end

endmodule

>>> best_fit_allocator_coalescing_unit.f
+incdir+hw/rtl
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_ram.sv
hw/rtl/best_fit_allocator_coalescing_unit.sv
test/tb_best_fit_allocator_coalescing_unit.sv
